// ===== design/vfrm_pkg.sv =====
// Shared types, constants and output rounding for the vertical resample MAC.
`timescale 1ns / 1ps
`default_nettype none

package vfrm_pkg;

  localparam int LANES      = 8;
  localparam int MAX_TAPS   = 64;
  localparam int PIX_W      = 16;
  localparam int ACC_W      = 32;
  localparam int TAP_W      = 7;
  localparam int MODE_W     = 2;
  localparam int APB_ADDR_W = 3;

  // arith_mode codes
  localparam logic [MODE_W-1:0] MODE_WIDE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HALF = 2'd1;

  // Register index, taken from paddr[2]
  localparam logic REG_ARITH_MODE = 1'b0;
  localparam logic REG_TAP_COUNT  = 1'b1;

  // -(32768 << 13) modulo 2^32, extra half rounder and full-precision rounder
  localparam logic [ACC_W-1:0] ROUND_BASE = 32'hF000_0000;
  localparam logic [ACC_W-1:0] ROUND_HALF = 32'd4096;
  localparam logic [ACC_W-1:0] ROUND_FULL = 32'd8192;

  typedef struct packed {
    logic p_load;    // capture the product of the input stage
    logic acc_step;  // add the held product into the accumulator
    logic acc_last;  // the step closes an output row
    logic f_load;    // capture the closing sum for rounding
  } vfrm_ctrl_t;

  // Round, shift and clamp one finished accumulator into a pixel.
  function automatic logic [PIX_W-1:0] vfrm_round(input logic [ACC_W-1:0] acc,
                                                  input logic             full,
                                                  input logic [ACC_W-1:0] rounder);
    logic [ACC_W-1:0] t;
    logic [PIX_W-1:0] px;
    t = acc + rounder;
    if (full) begin
      // value is t[31:14] as signed, clamp to 0..65535
      if (t[31]) begin
        px = '0;
      end else if (t[30]) begin
        px = '1;
      end else begin
        px = t[29:14];
      end
    end else begin
      // value is t[31:13] as signed, saturate to signed 16 and flip the top bit
      if (!t[31] && (t[30:28] != 3'b000)) begin
        px = '1;
      end else if (t[31] && (t[30:28] != 3'b111)) begin
        px = '0;
      end else begin
        px = {~t[28], t[27:13]};
      end
    end
    return px;
  endfunction

endpackage

`default_nettype wire

// ===== design/vfrm_lane.sv =====
// One lane: product register, wrapping accumulator and closing-sum register.
`timescale 1ns / 1ps
`default_nettype none

module vfrm_lane
  import vfrm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire vfrm_ctrl_t              ctrl,
  input  wire logic [PIX_W-1:0]        sample,
  input  wire logic signed [PIX_W-1:0] weight,
  input  wire logic                    mul_full,
  input  wire logic                    rnd_full,
  input  wire logic [ACC_W-1:0]        rnd_value,
  output logic      [PIX_W-1:0]        pixel
);

  logic        [PIX_W:0]   s_sel;
  logic signed [PIX_W+1:0] s_ext;
  logic signed [ACC_W:0]   prod_full;
  logic        [ACC_W-1:0] prod;
  logic        [ACC_W-1:0] acc;
  logic        [ACC_W-1:0] acc_sum;
  logic        [ACC_W-1:0] fin;

  // Halve the sample (modes 0 and 1) unless the full-precision path (modes 2 and 3) is selected.
  assign s_sel     = mul_full ? {1'b0, sample} : {2'b00, sample[PIX_W-1:1]};
  assign s_ext     = $signed({1'b0, s_sel});
  assign prod_full = s_ext * weight;
  assign acc_sum   = acc + prod;

  always_ff @(posedge clk) begin
    if (ctrl.p_load) begin
      prod <= prod_full[ACC_W-1:0];
    end
    if (ctrl.f_load) begin
      fin <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.acc_step) begin
      acc <= ctrl.acc_last ? '0 : acc_sum;
    end
  end

  assign pixel = vfrm_round(fin, rnd_full, rnd_value);

endmodule

`default_nettype wire

// ===== design/vertical_fir_resample_mac_unit.sv =====
// Top level of the vertical resample multiply-accumulate unit.
// Throughput: one tap per cycle while no last tap waits on a stalled output.
// Pipeline: input register, product register, closing-sum register, pixel register.
// Reset (rst, synchronous, active high) clears all valids and accumulators,
// and sets arith_mode to 0 and tap_count to 6.
`timescale 1ns / 1ps
`default_nettype none

module vertical_fir_resample_mac_unit
  import vfrm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // APB-style configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  // tap input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIX_W-1:0]      sample_0,
  input  wire logic [PIX_W-1:0]      sample_1,
  input  wire logic [PIX_W-1:0]      sample_2,
  input  wire logic [PIX_W-1:0]      sample_3,
  input  wire logic [PIX_W-1:0]      sample_4,
  input  wire logic [PIX_W-1:0]      sample_5,
  input  wire logic [PIX_W-1:0]      sample_6,
  input  wire logic [PIX_W-1:0]      sample_7,
  input  wire logic signed [PIX_W-1:0] tap_weight,
  input  wire logic                  last_tap,
  // pixel output channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [PIX_W-1:0]      pixel_0,
  output logic      [PIX_W-1:0]      pixel_1,
  output logic      [PIX_W-1:0]      pixel_2,
  output logic      [PIX_W-1:0]      pixel_3,
  output logic      [PIX_W-1:0]      pixel_4,
  output logic      [PIX_W-1:0]      pixel_5,
  output logic      [PIX_W-1:0]      pixel_6,
  output logic      [PIX_W-1:0]      pixel_7
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0] arith_mode;
  logic [TAP_W-1:0]  tap_count;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      arith_mode <= MODE_WIDE;
      tap_count  <= TAP_W'(6);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ARITH_MODE: arith_mode <= pwdata[MODE_W-1:0];
        REG_TAP_COUNT:  tap_count  <= pwdata[TAP_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ARITH_MODE: prdata = {{(32-MODE_W){1'b0}}, arith_mode};
      REG_TAP_COUNT:  prdata = {{(32-TAP_W){1'b0}}, tap_count};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Rounder for the current configuration. The high mode bit selects the
  // full-precision path (mode three acts as mode two). Tap counts above
  // MAX_TAPS saturate; a count of zero adds no compensation.
  // ---------------------------------------------------------------------------
  logic             cfg_full;
  logic [TAP_W-1:0] taps_sat;
  logic [ACC_W-1:0] rnd_now;

  assign cfg_full = arith_mode[1];
  assign taps_sat = (tap_count > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : tap_count;

  always_comb begin
    if (cfg_full) begin
      rnd_now = ROUND_FULL;
    end else begin
      rnd_now = ROUND_BASE + {{(ACC_W-TAP_W-12){1'b0}}, taps_sat, 12'b0};
      if (arith_mode == MODE_HALF) begin
        rnd_now = rnd_now + ROUND_HALF;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. Only last taps occupy the closing-sum and pixel stages, so a
  // waiting result holds back only the next last tap and the taps behind it;
  // ordinary taps ahead of it keep flowing into the accumulators.
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid, s2_last, s3_valid;
  logic out_free, s3_free, s2_adv, s1_adv;

  assign out_free = !out_valid || out_ready;
  assign s3_free  = !s3_valid || out_free;
  assign s2_adv   = !s2_valid || !s2_last || s3_free;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_ready = s1_adv;

  // Stage 1: input register. Mode and rounder are taken at the transfer, so
  // each tap multiplies under the mode current at that tap.
  logic        [PIX_W-1:0] s1_sample [LANES];
  logic signed [PIX_W-1:0] s1_weight;
  logic                    s1_last;
  logic                    s1_full;
  logic        [ACC_W-1:0] s1_rnd;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample[0] <= sample_0;
      s1_sample[1] <= sample_1;
      s1_sample[2] <= sample_2;
      s1_sample[3] <= sample_3;
      s1_sample[4] <= sample_4;
      s1_sample[5] <= sample_5;
      s1_sample[6] <= sample_6;
      s1_sample[7] <= sample_7;
      s1_weight    <= tap_weight;
      s1_last      <= last_tap;
      s1_full      <= cfg_full;
      s1_rnd       <= rnd_now;
    end
  end

  // Stage 2: products held in the lanes; carry the row-closing info along.
  logic             s2_full;
  logic [ACC_W-1:0] s2_rnd;
  logic             s3_full;
  logic [ACC_W-1:0] s3_rnd;

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      s2_last <= s1_last;
      s2_full <= s1_full;
      s2_rnd  <= s1_rnd;
    end
    if (s3_free && s2_valid && s2_last) begin
      s3_full <= s2_full;
      s3_rnd  <= s2_rnd;
    end
  end

  // Valid bits for all stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= in_valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        s3_valid <= s2_valid && s2_last;
      end
      if (out_free) begin
        out_valid <= s3_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Lanes
  // ---------------------------------------------------------------------------
  vfrm_ctrl_t       lane_ctrl;
  logic [PIX_W-1:0] lane_pix [LANES];
  logic [PIX_W-1:0] pix_q    [LANES];

  assign lane_ctrl.p_load   = s2_adv && s1_valid;
  assign lane_ctrl.acc_step = s2_valid && s2_adv;
  assign lane_ctrl.acc_last = s2_last;
  assign lane_ctrl.f_load   = s3_free && s2_valid && s2_last;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    vfrm_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (lane_ctrl),
      .sample    (s1_sample[g]),
      .weight    (s1_weight),
      .mul_full  (s1_full),
      .rnd_full  (s3_full),
      .rnd_value (s3_rnd),
      .pixel     (lane_pix[g])
    );
  end

  // Stage 4: pixel register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (out_free && s3_valid) begin
      pix_q <= lane_pix;
    end
  end

  assign pixel_0 = pix_q[0];
  assign pixel_1 = pix_q[1];
  assign pixel_2 = pix_q[2];
  assign pixel_3 = pix_q[3];
  assign pixel_4 = pix_q[4];
  assign pixel_5 = pix_q[5];
  assign pixel_6 = pix_q[6];
  assign pixel_7 = pix_q[7];

`ifndef SYNTHESIS
  // An ordinary tap in the product stage never blocks the input.
  a_tap_no_stall: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_last) |-> in_ready)
    else $error("input stalled behind an ordinary tap");

  // A new result only comes from a filled closing-sum stage.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s3_valid))
    else $error("result appeared without a closing sum");

  // A closing sum is held while the pixel register is blocked.
  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !out_free) |=> s3_valid)
    else $error("closing sum lost while output stalled");
`endif

endmodule

`default_nettype wire
